// ----- src/ieu_pkg.sv -----
// Package: shared types, operation codes and controller commands for the integer execute unit.
`timescale 1ns / 1ps
`default_nettype none
package ieu_pkg;
   typedef struct packed {
      logic [4:0]         func;
      logic [3:0]         dest_index;
      logic [3:0]         src_index;
      logic               use_immediate;
      logic signed [31:0] immediate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] write_value;
      logic               wrote_register;
      logic               jump_taken;
      logic [31:0]        jump_target;
      logic               error_code;
   } rsp_type;

   localparam logic [4:0] OP_MOV = 5'd0, OP_LEA = 5'd1, OP_EQ = 5'd2, OP_NE = 5'd3,
      OP_GT = 5'd4, OP_GE = 5'd5, OP_LT = 5'd6, OP_LE = 5'd7, OP_NOT = 5'd8,
      OP_AND = 5'd9, OP_OR = 5'd10, OP_XOR = 5'd11, OP_BNOT = 5'd12, OP_SHL = 5'd13,
      OP_ADD = 5'd14, OP_SUB = 5'd15, OP_MUL = 5'd16, OP_DIV = 5'd17, OP_MOD = 5'd18,
      OP_NEG = 5'd19, OP_ABS = 5'd20, OP_MIN = 5'd21, OP_MAX = 5'd22,
      OP_TOBOOL = 5'd23, OP_JMP = 5'd24, OP_JT = 5'd25, OP_JF = 5'd26;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture request, read operands
      logic exec;       // compute single-cycle result into output register
      logic div_start;  // start iterative divider
      logic div_step;   // one divider iteration
      logic div_finish; // form divide/mod result into output register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_div;     // captured op is div/mod with nonzero divisor
      logic div_last;   // divider on its final iteration
   } sts_type;
endpackage
`default_nettype wire

// ----- src/ieu_ctrl.sv -----
// Controller: sequences one request through operand read, execute or divide, and output.
`timescale 1ns / 1ps
`default_nettype none
module ieu_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire ieu_pkg::sts_type sts,
   output ieu_pkg::cmd_type      cmd
);
   import ieu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0, ST_EXEC = 2'd1, ST_DIV = 2'd2, ST_OUT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   // take a request in idle, or while the finished result is being taken
   assign req_stall = !((state_ff == ST_IDLE) || (state_ff == ST_OUT && !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      cmd = '0;
      cmd.load = accept;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            if (sts.is_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.div_finish = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

`ifndef NO_ASSERTIONS
   a_div_only_from_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> state_ff == ST_DIV) else $error("divider start lost");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped under stall");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC || state_ff == ST_DIV) |-> req_stall)
      else $error("request accepted while busy");
`endif
endmodule
`default_nettype wire

// ----- src/ieu_datapath.sv -----
// Datapath: register file, single-cycle ALU, radix-2 divider and output register.
`timescale 1ns / 1ps
`default_nettype none
module ieu_datapath #(
   parameter int NUM_REGS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ieu_pkg::req_type req_data,
   input  wire ieu_pkg::cmd_type cmd,
   output ieu_pkg::sts_type      sts,
   output ieu_pkg::rsp_type      rsp_data
);
   import ieu_pkg::*;

   localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   // fold a 4-bit index into the register count by repeated subtraction
   function automatic logic [IW-1:0] reduce_index(logic [3:0] idx);
      logic [6:0] v;
      v = {3'b000, idx};
      for (int k = 0; k < 16; k++) begin
         if (v >= 7'(NUM_REGS)) v = v - 7'(NUM_REGS);
      end
      return v[IW-1:0];
   endfunction

   logic [31:0] regs_ff [NUM_REGS];
   logic [4:0]  func_ff;
   logic [IW-1:0] di_ff;
   logic        use_imm_ff;
   logic [31:0] imm_ff, a_ff, r2_ff;
   rsp_type     rsp_ff;
   logic [IW-1:0] di_in, si_in;

   // reduce indices modulo the register count
   assign di_in = reduce_index(req_data.dest_index);
   assign si_in = reduce_index(req_data.src_index);

   // capture request and operands
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_data.func;
         di_ff      <= di_in;
         use_imm_ff <= req_data.use_immediate;
         imm_ff     <= req_data.immediate;
         a_ff       <= regs_ff[di_in];
         r2_ff      <= regs_ff[si_in];
      end
   end

   logic [31:0] b;
   logic signed [31:0] sa, sb;
   assign b  = use_imm_ff ? imm_ff : r2_ff;
   assign sa = a_ff;
   assign sb = b;

   // divider: unsigned restoring on magnitudes, one quotient bit per cycle
   logic [31:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [32:0] trial;

   assign sts.is_div   = (func_ff == OP_DIV || func_ff == OP_MOD) && (b != 32'd0);
   assign sts.div_last = (cnt_ff == 5'd31);
   assign trial        = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      qneg_in = qneg_ff; rneg_in = rneg_ff;
      if (cmd.div_start) begin
         quo_in  = a_ff[31] ? 32'd0 - a_ff : a_ff;
         dvs_in  = b[31] ? 32'd0 - b : b;
         rem_in  = '0;
         cnt_in  = '0;
         qneg_in = a_ff[31] ^ b[31];
         rneg_in = a_ff[31];
      end else if (cmd.div_step) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
   end

   // single-cycle result
   logic [31:0] res, mag, tgt;
   logic        wr, jmp, err;
   always_comb begin
      res = '0; wr = 1'b1; jmp = 1'b0; tgt = '0; err = 1'b0;
      mag = b[31] ? 32'd0 - b : b;
      case (func_ff)
         OP_MOV:    res = b;
         OP_LEA:    res = use_imm_ff ? r2_ff + imm_ff : r2_ff;
         OP_EQ:     res = {31'd0, sa == sb};
         OP_NE:     res = {31'd0, sa != sb};
         OP_GT:     res = {31'd0, sa > sb};
         OP_GE:     res = {31'd0, sa >= sb};
         OP_LT:     res = {31'd0, sa < sb};
         OP_LE:     res = {31'd0, sa <= sb};
         OP_NOT:    res = ~a_ff;
         OP_AND:    res = a_ff & b;
         OP_OR:     res = a_ff | b;
         OP_XOR:    res = a_ff ^ b;
         OP_BNOT:   res = {31'd0, a_ff == 32'd0};
         OP_SHL: begin
            if (mag >= 32'd32) res = '0;
            else if (sb > 0) res = a_ff << mag[4:0];
            else res = a_ff >> mag[4:0];
         end
         OP_ADD:    res = a_ff + b;
         OP_SUB:    res = a_ff - b;
         OP_MUL:    res = a_ff * b;
         OP_DIV, OP_MOD: begin
            wr = 1'b0; err = 1'b1;
         end
         OP_NEG:    res = 32'd0 - a_ff;
         OP_ABS:    res = a_ff[31] ? 32'd0 - a_ff : a_ff;
         OP_MIN:    res = (sa < sb) ? a_ff : b;
         OP_MAX:    res = (sa > sb) ? a_ff : b;
         OP_TOBOOL: res = {31'd0, a_ff != 32'd0};
         OP_JMP: begin
            wr = 1'b0; jmp = 1'b1; tgt = use_imm_ff ? imm_ff : a_ff;
         end
         OP_JT, OP_JF: begin
            wr = 1'b0;
            jmp = (func_ff == OP_JT) ? (a_ff != 32'd0) : (a_ff == 32'd0);
            tgt = jmp ? b : 32'd0;
         end
         default:   wr = 1'b0;
      endcase
   end

   // load output register and write back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else if (cmd.exec) begin
         if (wr) regs_ff[di_ff] <= res;
      end else if (cmd.div_finish) begin
         regs_ff[di_ff] <= (func_ff == OP_DIV) ? (qneg_ff ? 32'd0 - quo_in : quo_in)
                                               : (rneg_ff ? 32'd0 - rem_in : rem_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff.write_value    <= wr ? res : 32'd0;
         rsp_ff.wrote_register <= wr;
         rsp_ff.jump_taken     <= jmp;
         rsp_ff.jump_target    <= tgt;
         rsp_ff.error_code     <= err;
      end else if (cmd.div_finish) begin
         rsp_ff.write_value    <= (func_ff == OP_DIV) ? (qneg_ff ? 32'd0 - quo_in : quo_in)
                                                      : (rneg_ff ? 32'd0 - rem_in : rem_in);
         rsp_ff.wrote_register <= 1'b1;
         rsp_ff.jump_taken     <= 1'b0;
         rsp_ff.jump_target    <= '0;
         rsp_ff.error_code     <= 1'b0;
      end
   end

   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// ----- src/integer_execute_unit.sv -----
// Top level: integer execute unit with register file and iterative divider.
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid/req_stall   | req_data (ieu_pkg::req_type)
//  rsp_    | out       | rsp_valid/rsp_stall   | rsp_data (ieu_pkg::rsp_type)
// Most requests pass through operand read and execute; a new one is taken as
// the result leaves. Divide and modulo with nonzero divisor instead run 32
// iterations of the one-bit restoring divider. Synchronous reset clears the
// register file to zero and puts the controller back in idle.
// A stalled result holds in the output register; the next request waits.
`timescale 1ns / 1ps
`default_nettype none
module integer_execute_unit #(
   parameter int NUM_REGS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ieu_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ieu_pkg::rsp_type      rsp_data
);
   import ieu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ieu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   ieu_datapath #(.NUM_REGS(NUM_REGS)) u_datapath (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd),
      .sts(sts), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire
